[hw/rtl/dashboard_led_and_button_controller_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the dashboard LED and button controller
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DASHBOARD_LED_AND_BUTTON_CONTROLLER_CORE_ASSERT_SVH
`define DASHBOARD_LED_AND_BUTTON_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication.
`define DLBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DLBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/dlbc_pkg.sv]
// ----------------------------------------------------------------------------
// dlbc_pkg
// Shared types and constants of the dashboard LED and button controller.
// ----------------------------------------------------------------------------
package dlbc_pkg;

  // LED combination driven by the blink engine
  typedef enum logic [1:0] {
    COMB_TS   = 2'd0,
    COMB_RTD  = 2'd1,
    COMB_SYNC = 2'd2,
    COMB_ALT  = 2'd3
  } comb_t;

  // Motor controller states
  localparam logic [1:0] CSTATE_OTHER    = 2'd0;
  localparam logic [1:0] CSTATE_DISABLE  = 2'd1;
  localparam logic [1:0] CSTATE_ERROR    = 2'd2;
  localparam logic [1:0] CSTATE_OVERHEAT = 2'd3;

  // Drive modes
  localparam logic [1:0] MODE_NORMAL    = 2'd0;
  localparam logic [1:0] MODE_SLOW      = 2'd1;
  localparam logic [1:0] MODE_ENDURANCE = 2'd2;

  // Configuration register indexes
  localparam logic CFG_UPDATE_PERIOD = 1'b0;
  localparam logic CFG_DEBOUNCE_TIME = 1'b1;

  localparam int unsigned CFG_W = 10;

  // Blink timings in ms
  localparam int unsigned BLINK_W = 11;
  localparam logic [BLINK_W-1:0] SYNC_ON_MS  = 11'd1500;
  localparam logic [BLINK_W-1:0] SYNC_OFF_MS = 11'd500;
  localparam logic [BLINK_W-1:0] FAST_MS     = 11'd125;
  localparam logic [BLINK_W-1:0] ALT_MS      = 11'd500;

  // Debounce status of one button
  typedef struct packed {
    logic run;
    logic flag;
  } deb_ctl_t;

endpackage

[hw/rtl/dashboard_led_and_button_controller_core.sv]
// ----------------------------------------------------------------------------
// dashboard_led_and_button_controller_core
// Dashboard LED pattern, ASSI color and button debounce for one 1 ms tick.
// ----------------------------------------------------------------------------
// Usage:
//   Each input beat on in_* is one 1 ms tick with sampled car status. For
//   every input beat exactly one output beat comes out on out_*, holding the
//   LED, ASSI and pressed-flag levels after that tick.
//   The cfg_* channel writes update_period (index 0) and debounce_time
//   (index 1); it is always ready. Write it only while the block is idle.
// Stages and throughput:
//   Two register stages: the input register captures the beat, and the tick
//   is evaluated between it and the result register, which then raises
//   out_valid. One beat per cycle is sustained while out_ready is high; the
//   limit is the single evaluation of the timer and LED logic per cycle.
// Stall:
//   If out_ready is low, the result register holds; the input register still
//   takes one more beat, then in_ready drops until the result is taken.
// Reset:
//   rst_n low (synchronous) empties both stages, stops all timers, restores
//   update_period 10 and debounce_time 50; the out_* levels are not reset.
// ----------------------------------------------------------------------------
`include "dashboard_led_and_button_controller_core_assert.svh"

module dashboard_led_and_button_controller_core #(
  parameter int TIMER_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_starting_up,
  input  logic                        in_rtd_button,
  input  logic                        in_ts_button,
  input  logic [1:0]                  in_controller_state,
  input  logic [1:0]                  in_drive_mode,
  input  logic                        in_shutdown_pressed,
  input  logic                        in_driverless_on,
  input  logic                        in_ctrl_rtd_led,
  input  logic                        in_ctrl_ts_led,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_rtd_led,
  output logic                        out_ts_led,
  output logic                        out_assi_red,
  output logic                        out_assi_green,
  output logic                        out_assi_blue,
  output logic                        out_ts_pressed,
  output logic                        out_rtd_pressed,
  // configuration channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [dlbc_pkg::CFG_W-1:0]  cfg_data
);

  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  // Saturating increment
  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] t);
    sat_inc = (t == TMAX) ? t : t + TIMER_BITS'(1);
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [dlbc_pkg::CFG_W-1:0] period_r;
  logic [dlbc_pkg::CFG_W-1:0] db_time_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= dlbc_pkg::CFG_W'(10);
      db_time_r <= dlbc_pkg::CFG_W'(50);
    end else if (cfg_valid) begin
      case (cfg_index)
        dlbc_pkg::CFG_UPDATE_PERIOD: period_r  <= cfg_data;
        dlbc_pkg::CFG_DEBOUNCE_TIME: db_time_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic       s1_valid_r;
  logic       s1_start_r, s1_rtd_b_r, s1_ts_b_r, s1_sdc_r, s1_dv_r;
  logic       s1_c_rtd_r, s1_c_ts_r;
  logic [1:0] s1_cstate_r, s1_mode_r;
  logic       out_valid_r;
  logic       adv;

  // Advance the input register into the result register when it has room.
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_start_r  <= in_starting_up;
      s1_rtd_b_r  <= in_rtd_button;
      s1_ts_b_r   <= in_ts_button;
      s1_cstate_r <= in_controller_state;
      s1_mode_r   <= in_drive_mode;
      s1_sdc_r    <= in_shutdown_pressed;
      s1_dv_r     <= in_driverless_on;
      s1_c_rtd_r  <= in_ctrl_rtd_led;
      s1_c_ts_r   <= in_ctrl_ts_led;
    end
  end

  // --------------------------------------------------------------------------
  // Controller state
  // --------------------------------------------------------------------------
  logic [TIMER_BITS-1:0] upd_el_r, upd_el_nxt;
  logic [TIMER_BITS-1:0] blk_el_r, blk_el_nxt;
  logic                  blk_run_r, blk_run_nxt;
  dlbc_pkg::comb_t       lcomb_r, lcomb_nxt;
  logic                  lbv_r, lbv_nxt;
  logic [TIMER_BITS-1:0] ts_el_r, ts_el_nxt, rtd_el_r, rtd_el_nxt;
  dlbc_pkg::deb_ctl_t    ts_ctl_r, ts_ctl_nxt, rtd_ctl_r, rtd_ctl_nxt;
  logic                  rtd_led_r, rtd_led_nxt, ts_led_r, ts_led_nxt;
  logic                  red_r, red_nxt, green_r, green_nxt, blue_r, blue_nxt;

  // Advance running timers first.
  logic [TIMER_BITS-1:0] upd_tick, blk_tick, ts_tick, rtd_tick;
  logic                  upd_fire;

  assign upd_tick = sat_inc(upd_el_r);
  assign blk_tick = blk_run_r ? sat_inc(blk_el_r) : blk_el_r;
  assign ts_tick  = ts_ctl_r.run ? sat_inc(ts_el_r) : ts_el_r;
  assign rtd_tick = rtd_ctl_r.run ? sat_inc(rtd_el_r) : rtd_el_r;
  assign upd_fire = upd_tick >= TIMER_BITS'(period_r);

  // Pattern selection
  logic                          blk_req;
  logic [dlbc_pkg::BLINK_W-1:0]  blk_on, blk_off;
  logic [dlbc_pkg::BLINK_W:0]    blk_sum;
  dlbc_pkg::comb_t               blk_comb;
  logic                          led_set;
  logic                          led_rtd_v, led_ts_v;

  always_comb begin
    blk_req   = 1'b0;
    blk_on    = dlbc_pkg::FAST_MS;
    blk_off   = dlbc_pkg::FAST_MS;
    blk_comb  = dlbc_pkg::COMB_TS;
    led_set   = 1'b0;
    led_rtd_v = 1'b0;
    led_ts_v  = 1'b0;
    if (s1_start_r) begin
      blk_req  = 1'b1;
      blk_on   = dlbc_pkg::SYNC_ON_MS;
      blk_off  = dlbc_pkg::SYNC_OFF_MS;
      blk_comb = dlbc_pkg::COMB_SYNC;
    end else if (s1_rtd_b_r || s1_ts_b_r) begin
      // echo the buttons
      led_set   = 1'b1;
      led_rtd_v = s1_rtd_b_r;
      led_ts_v  = s1_ts_b_r;
    end else if (s1_cstate_r == dlbc_pkg::CSTATE_OVERHEAT) begin
      blk_req  = 1'b1;
      blk_comb = dlbc_pkg::COMB_RTD;
    end else if (s1_cstate_r == dlbc_pkg::CSTATE_ERROR) begin
      blk_req  = 1'b1;
      blk_comb = dlbc_pkg::COMB_TS;
    end else if (s1_cstate_r == dlbc_pkg::CSTATE_DISABLE && s1_sdc_r) begin
      case (s1_mode_r)
        dlbc_pkg::MODE_NORMAL: begin
          led_set = 1'b1;
        end
        dlbc_pkg::MODE_SLOW: begin
          blk_req  = 1'b1;
          blk_on   = dlbc_pkg::ALT_MS;
          blk_off  = dlbc_pkg::ALT_MS;
          blk_comb = dlbc_pkg::COMB_ALT;
        end
        dlbc_pkg::MODE_ENDURANCE: begin
          led_set   = 1'b1;
          led_rtd_v = 1'b1;
          led_ts_v  = 1'b1;
        end
        default: ; // undefined mode: leave the LEDs alone
      endcase
    end else begin
      // pass the controller's request through
      led_set   = 1'b1;
      led_rtd_v = s1_c_rtd_r;
      led_ts_v  = s1_c_ts_r;
    end
  end

  assign blk_sum = {1'b0, blk_on} + {1'b0, blk_off};

  // Blink engine: at most one value is applied per update.
  logic [TIMER_BITS-1:0] blk_past;
  logic                  blk_done, apply_en, apply_val;

  assign blk_past  = blk_run_r ? blk_tick : '0;
  assign blk_done  = blk_past >= TIMER_BITS'(blk_sum);
  assign apply_val = !blk_run_r;
  assign apply_en  = !blk_run_r || (!blk_done && (blk_past > TIMER_BITS'(blk_on)));

  always_comb begin
    upd_el_nxt  = upd_tick;
    blk_el_nxt  = blk_tick;
    blk_run_nxt = blk_run_r;
    lcomb_nxt   = lcomb_r;
    lbv_nxt     = lbv_r;
    rtd_led_nxt = rtd_led_r;
    ts_led_nxt  = ts_led_r;
    red_nxt     = red_r;
    green_nxt   = green_r;
    blue_nxt    = blue_r;
    if (upd_fire) begin
      upd_el_nxt = '0;
      if (led_set) begin
        rtd_led_nxt = led_rtd_v;
        ts_led_nxt  = led_ts_v;
      end
      if (blk_req) begin
        if (!blk_run_r) begin
          blk_run_nxt = 1'b1;
          blk_el_nxt  = '0;
        end else if (blk_done) begin
          blk_run_nxt = 1'b0;
          blk_el_nxt  = '0;
        end
        if (apply_en && (apply_val != lbv_r)) begin
          lbv_nxt = apply_val;
          // a new combination starts from both LEDs dark
          if (blk_comb != lcomb_r) begin
            lcomb_nxt   = blk_comb;
            rtd_led_nxt = 1'b0;
            ts_led_nxt  = 1'b0;
          end
          case (blk_comb)
            dlbc_pkg::COMB_TS:   ts_led_nxt = apply_val;
            dlbc_pkg::COMB_RTD:  rtd_led_nxt = apply_val;
            dlbc_pkg::COMB_SYNC: begin
              ts_led_nxt  = apply_val;
              rtd_led_nxt = apply_val;
            end
            default: begin
              ts_led_nxt  = apply_val;
              rtd_led_nxt = !apply_val;
            end
          endcase
        end
      end
      // ASSI: white while starting up, yellow when driverless, else dark
      red_nxt   = s1_start_r || s1_dv_r;
      green_nxt = s1_start_r || s1_dv_r;
      blue_nxt  = s1_start_r;
    end
  end

  // Button debouncers run only on updates outside start-up.
  logic deb_en;
  assign deb_en = upd_fire && !s1_start_r;

  dlbc_debounce #(.TIMER_BITS(TIMER_BITS)) u_ts_deb (
    .en            (deb_en),
    .held          (s1_ts_b_r),
    .debounce_time (db_time_r),
    .el_cur        (ts_tick),
    .ctl_cur       (ts_ctl_r),
    .el_nxt        (ts_el_nxt),
    .ctl_nxt       (ts_ctl_nxt)
  );

  dlbc_debounce #(.TIMER_BITS(TIMER_BITS)) u_rtd_deb (
    .en            (deb_en),
    .held          (s1_rtd_b_r),
    .debounce_time (db_time_r),
    .el_cur        (rtd_tick),
    .ctl_cur       (rtd_ctl_r),
    .el_nxt        (rtd_el_nxt),
    .ctl_nxt       (rtd_ctl_nxt)
  );

  // Commit the tick's state on advance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upd_el_r  <= '0;
      blk_el_r  <= '0;
      blk_run_r <= 1'b0;
      lcomb_r   <= dlbc_pkg::COMB_TS;
      lbv_r     <= 1'b0;
      ts_el_r   <= '0;
      ts_ctl_r  <= '0;
      rtd_el_r  <= '0;
      rtd_ctl_r <= '0;
      rtd_led_r <= 1'b0;
      ts_led_r  <= 1'b0;
      red_r     <= 1'b0;
      green_r   <= 1'b0;
      blue_r    <= 1'b0;
    end else if (adv) begin
      upd_el_r  <= upd_el_nxt;
      blk_el_r  <= blk_el_nxt;
      blk_run_r <= blk_run_nxt;
      lcomb_r   <= lcomb_nxt;
      lbv_r     <= lbv_nxt;
      ts_el_r   <= ts_el_nxt;
      ts_ctl_r  <= ts_ctl_nxt;
      rtd_el_r  <= rtd_el_nxt;
      rtd_ctl_r <= rtd_ctl_nxt;
      rtd_led_r <= rtd_led_nxt;
      ts_led_r  <= ts_led_nxt;
      red_r     <= red_nxt;
      green_r   <= green_nxt;
      blue_r    <= blue_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rtd_led     <= rtd_led_nxt;
      out_ts_led      <= ts_led_nxt;
      out_assi_red    <= red_nxt;
      out_assi_green  <= green_nxt;
      out_assi_blue   <= blue_nxt;
      out_ts_pressed  <= ts_ctl_nxt.flag;
      out_rtd_pressed <= rtd_ctl_nxt.flag;
    end
  end

  assign out_valid = out_valid_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `DLBC_ASSERT_NOW(a_ready_when_empty, !s1_valid_r, in_ready,
    "input register empty but not ready")
  `DLBC_ASSERT_NEXT(a_update_restarts, adv && upd_fire, upd_el_r == '0,
    "update timer not restarted after an update")
  `DLBC_ASSERT_NEXT(a_startup_white, adv && upd_fire && s1_start_r,
    red_r && green_r && blue_r, "ASSI not white during start-up update")
  `DLBC_ASSERT_NEXT(a_release_clears, adv && deb_en && !s1_ts_b_r,
    !ts_ctl_r.flag && !ts_ctl_r.run, "released TS button left flag or timer set")

endmodule

[hw/rtl/dlbc_debounce.sv]
// ----------------------------------------------------------------------------
// dlbc_debounce
// Next-state logic of one button debouncer: hold timer and pressed flag.
// ----------------------------------------------------------------------------
module dlbc_debounce #(
  parameter int TIMER_BITS = 16
) (
  input  logic                          en,
  input  logic                          held,
  input  logic [dlbc_pkg::CFG_W-1:0]    debounce_time,
  input  logic [TIMER_BITS-1:0]         el_cur,
  input  dlbc_pkg::deb_ctl_t            ctl_cur,
  output logic [TIMER_BITS-1:0]         el_nxt,
  output dlbc_pkg::deb_ctl_t            ctl_nxt
);

  logic [TIMER_BITS-1:0] el_eff;

  // A stopped timer restarts at zero.
  assign el_eff = ctl_cur.run ? el_cur : '0;

  always_comb begin
    el_nxt  = el_cur;
    ctl_nxt = ctl_cur;
    if (en) begin
      if (!held) begin
        el_nxt       = '0;
        ctl_nxt.run  = 1'b0;
        ctl_nxt.flag = 1'b0;
      end else if (el_eff >= TIMER_BITS'(debounce_time)) begin
        el_nxt       = '0;
        ctl_nxt.run  = 1'b0;
        ctl_nxt.flag = 1'b1;
      end else begin
        el_nxt      = el_eff;
        ctl_nxt.run = 1'b1;
      end
    end
  end

endmodule
